// ===== rtl/core/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg: shared definitions for the Lehmer generator with shuffle table
// Widths, generator constants, controller states and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int VALUE_W      = 31;
    localparam int MUL_W        = 15;
    localparam int PROD_W       = VALUE_W + MUL_W;
    localparam int TABLE_SIZE   = 32;
    localparam int IDX_W        = $clog2(TABLE_SIZE);
    localparam int WARMUP_STEPS = 8;
    localparam int WARM_W       = $clog2(WARMUP_STEPS);

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [WARM_W-1:0]  warm_t;
    typedef logic [PROD_W-1:0]  prod_t;

    localparam value_t             LEHMER_MOD = {VALUE_W{1'b1}};
    localparam logic [MUL_W-1:0]   LEHMER_MUL = MUL_W'(16807);
    localparam value_t             SEED_ONE   = VALUE_W'(1);
    localparam idx_t               IDX_LAST   = IDX_W'(TABLE_SIZE - 1);
    localparam warm_t              WARM_LAST  = WARM_W'(WARMUP_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_WARM_MUL,
        ST_WARM_RED,
        ST_FILL_MUL,
        ST_FILL_RED,
        ST_DRAW_MUL,
        ST_DRAW_RED
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic seed_load;
        logic step;
        logic fill_wr;
        logic fill_last;
        logic draw_wr;
        idx_t fill_idx;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic loaded;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/core/lps_in_if.sv =====
// ----------------------------------------------------------------------------
// lps_in_if: request channel
// Carries one request item: the operation and the seed.
// ----------------------------------------------------------------------------
interface lps_in_if;
    logic            valid;
    logic            ready;
    logic            op;
    lps_pkg::value_t seed;

    modport source (output valid, output op, output seed, input ready);
    modport sink   (input valid, input op, input seed, output ready);
endinterface

// ===== rtl/core/lps_out_if.sv =====
// ----------------------------------------------------------------------------
// lps_out_if: result channel
// Carries one result item: the shuffled random value.
// ----------------------------------------------------------------------------
interface lps_out_if;
    logic            valid;
    logic            ready;
    lps_pkg::value_t value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/core/lps_ram.sv =====
// ----------------------------------------------------------------------------
// lps_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lps_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lps_ctrl.sv =====
// ----------------------------------------------------------------------------
// lps_ctrl: sequencer for seeding, warm-up, table fill and draws
// Steps the datapath through each generator step as a multiply state and a
// reduce state, and handles the request handshake.
// ----------------------------------------------------------------------------
module lps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_op,
    output logic                in_ready,
    input  lps_pkg::dp_status_t status,
    output lps_pkg::ctl_cmd_t   cmd
);
    import lps_pkg::*;

    state_t state_reg;
    state_t state_next;
    warm_t  warm_reg;
    warm_t  warm_next;
    idx_t   idx_reg;
    idx_t   idx_next;
    state_t accept_state;

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            warm_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            warm_reg  <= warm_next;
            idx_reg   <= idx_next;
        end
    end

    // A reseed request, or a draw before any load, starts a full load.
    assign accept_state = (in_op || !status.loaded) ? ST_SEED : ST_DRAW_MUL;

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        warm_next    = warm_reg;
        idx_next     = idx_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.fill_idx = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = accept_state;
                end
            end
            ST_SEED:
            begin
                cmd.seed_load = 1'b1;
                warm_next     = '0;
                state_next    = ST_WARM_MUL;
            end
            ST_WARM_MUL:
            begin
                state_next = ST_WARM_RED;
            end
            ST_WARM_RED:
            begin
                cmd.step = 1'b1;
                if (warm_reg == WARM_LAST)
                begin
                    idx_next   = IDX_LAST;
                    state_next = ST_FILL_MUL;
                end
                else
                begin
                    warm_next  = warm_reg + 1'b1;
                    state_next = ST_WARM_MUL;
                end
            end
            ST_FILL_MUL:
            begin
                state_next = ST_FILL_RED;
            end
            ST_FILL_RED:
            begin
                cmd.step    = 1'b1;
                cmd.fill_wr = 1'b1;
                if (idx_reg == '0)
                begin
                    cmd.fill_last = 1'b1;
                    state_next    = ST_DRAW_MUL;
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_FILL_MUL;
                end
            end
            ST_DRAW_MUL:
            begin
                // Hold here until the result register can take the item.
                if (status.out_free)
                begin
                    state_next = ST_DRAW_RED;
                end
            end
            ST_DRAW_RED:
            begin
                cmd.step    = 1'b1;
                cmd.draw_wr = 1'b1;
                in_ready    = 1'b1;
                state_next  = ST_IDLE;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = accept_state;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/lps_datapath.sv =====
// ----------------------------------------------------------------------------
// lps_datapath: generator state, modular multiply and shuffle table
// Holds the generator state, the registered product, the last output, the
// shuffle table memory and the result register.
// ----------------------------------------------------------------------------
module lps_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  lps_pkg::ctl_cmd_t   cmd,
    output lps_pkg::dp_status_t status,
    input  logic                in_op,
    input  lps_pkg::value_t     in_seed,
    input  logic                out_ready,
    output logic                out_valid,
    output lps_pkg::value_t     out_value
);
    import lps_pkg::*;

    value_t           seed_reg;
    value_t           gen_reg;
    value_t           gen_next;
    prod_t            prod_reg;
    value_t           last_reg;
    value_t           last_next;
    logic             out_valid_reg;
    value_t           out_value_reg;
    logic [VALUE_W:0] fold_sum;
    logic [VALUE_W:0] fold_sub;
    value_t           reduced;
    value_t           seed_clean;
    idx_t             sel_idx;
    logic             ram_we;
    idx_t             ram_waddr;
    value_t           ram_rdata;

    // Registered product of the current state and the multiplier; latched seed.
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(gen_reg) * PROD_W'(LEHMER_MUL);
        if (cmd.latch_in)
        begin
            seed_reg <= in_op ? in_seed : SEED_ONE;
        end
    end

    // Reduction modulo 2^31-1: fold the high bits onto the low bits, then
    // one conditional subtract.
    assign fold_sum = {1'b0, prod_reg[VALUE_W-1:0]} + (VALUE_W+1)'(prod_reg[PROD_W-1:VALUE_W]);
    assign fold_sub = fold_sum - {1'b0, LEHMER_MOD};
    assign reduced  = (fold_sum >= {1'b0, LEHMER_MOD}) ? fold_sub[VALUE_W-1:0]
                                                      : fold_sum[VALUE_W-1:0];

    // A zero seed, or one equal to the modulus, would lock the generator at zero.
    assign seed_clean = (seed_reg == '0 || seed_reg == LEHMER_MOD) ? SEED_ONE : seed_reg;

    // The top bits of the last output select the table entry.
    assign sel_idx = last_reg[VALUE_W-1 -: IDX_W];

    assign ram_we    = cmd.fill_wr | cmd.draw_wr;
    assign ram_waddr = cmd.draw_wr ? sel_idx : cmd.fill_idx;

    lps_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (reduced),
        .raddr (sel_idx),
        .rdata (ram_rdata)
    );

    // Next values of the generator state and the last output.
    always_comb
    begin
        gen_next = gen_reg;
        if (cmd.seed_load)
        begin
            gen_next = seed_clean;
        end
        else if (cmd.step)
        begin
            gen_next = reduced;
        end

        last_next = last_reg;
        if (cmd.fill_last)
        begin
            last_next = reduced;
        end
        else if (cmd.draw_wr)
        begin
            last_next = ram_rdata;
        end
    end

    // Generator state, last output and result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg       <= SEED_ONE;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gen_reg  <= gen_next;
            last_reg <= last_next;
            if (cmd.draw_wr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.draw_wr)
        begin
            out_value_reg <= ram_rdata;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_value       = out_value_reg;
    assign status.loaded   = (last_reg != '0);
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

// ===== rtl/core/lehmer_prng_with_shuffle_top.sv =====
// ----------------------------------------------------------------------------
// lehmer_prng_with_shuffle_top: Lehmer generator with a shuffle table
// Sequence: a draw on a loaded table passes through the multiply state, where
// it waits while the result register is full, then the reduce state; a reseed,
// or a first draw, first loads the seed, runs the warm-up steps and fills the
// table. The next request item is taken in the reduce state of a draw.
// Reset: rst_n is asynchronous, active low; the generator state resets to 1 and
// the table counts as not loaded, so the first draw loads it with seed 1.
// ----------------------------------------------------------------------------
module lehmer_prng_with_shuffle_top (
    input logic     clk,
    input logic     rst_n,
    lps_in_if.sink  draw,
    lps_out_if.source result
);
    import lps_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    // Sequencer.
    lps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (draw.valid),
        .in_op    (draw.op),
        .in_ready (draw.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Generator, table and result register.
    lps_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_op     (draw.op),
        .in_seed   (draw.seed),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .out_value (result.value)
    );

endmodule

// ===== dv/tb_lehmer_prng_with_shuffle_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lehmer_prng_with_shuffle_top: self-checking bench for the shuffled
// Lehmer generator
// Request items (draw or reseed-and-draw) go in from a queue through a clocked
// driver. A clocked monitor checks each result item against values predicted
// by an in-bench copy of the generator and its shuffle table. Both sides
// idle at random. The receiver also holds off for a long stretch, and the
// sender sometimes waits until every predicted value has come back.
// ----------------------------------------------------------------------------
module tb_lehmer_prng_with_shuffle_top;
    import lps_pkg::*;

    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    localparam int ITEM_TARGET    = 1450;
    localparam int IDLE_PCT       = 6;
    localparam int CALM_FIRST     = 600;
    localparam int CALM_LAST      = 900;
    localparam int RX_HOLD_AT     = 300;
    localparam int RX_HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES    = 200;
    localparam int PRINT_LIMIT    = 100;
    localparam longint TIMEOUT_NS = 2_000_000;

    localparam longint unsigned SEL_DIV = 1 + (64'(LEHMER_MOD) - 1) / TABLE_SIZE;

    typedef struct {
        logic   op;
        value_t seed;
        bit     drain_first;
    } request_t;

    logic clk = 1'b0;
    logic rst_n;

    lps_in_if  draw_if ();
    lps_out_if result_if ();

    lehmer_prng_with_shuffle_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .draw   (draw_if),
        .result (result_if)
    );

    request_t pending_requests[$];
    value_t   expected_values[$];
    int       sent_count;
    int       got_count;
    int       mismatch_count;
    bit       rx_hold;

    // Generator copy: state, shuffle table and the previous output.
    value_t prd_state;
    value_t prd_table [TABLE_SIZE];
    value_t prd_prev;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        draw_if.valid = 1'b0;
        draw_if.op = OP_DRAW;
        draw_if.seed = '0;
        result_if.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH at %0t ns, result %0d: %s", $time, got_count, what);
        mismatch_count++;
    endtask

    // One multiplicative step modulo 2^31-1.
    function automatic value_t lehmer_advance(value_t s);
        longint unsigned prod;
        prod = 64'(s) * 64'(LEHMER_MUL);
        return value_t'(prod % 64'(LEHMER_MOD));
    endfunction

    // Seed, warm up, then fill the table from the top entry down.
    function automatic void prime_shuffle(value_t seed);
        value_t s;
        s = seed;
        if (s == '0 || s >= LEHMER_MOD)
            s = SEED_ONE;
        for (int i = 0; i < WARMUP_STEPS; i++)
            s = lehmer_advance(s);
        for (int i = TABLE_SIZE - 1; i >= 0; i--)
        begin
            s = lehmer_advance(s);
            prd_table[i] = s;
        end
        prd_state = s;
        prd_prev = prd_table[0];
    endfunction

    // Value returned for one request item; updates the generator copy.
    function automatic value_t predict_value(logic op, value_t seed);
        longint unsigned slot;
        if (op == OP_RESEED)
            prime_shuffle(seed);
        else if (prd_prev == '0)
            prime_shuffle(SEED_ONE);
        prd_state = lehmer_advance(prd_state);
        slot = 64'(prd_prev) / SEL_DIV;
        if (slot >= TABLE_SIZE)
            slot = TABLE_SIZE - 1;
        prd_prev = prd_table[slot];
        prd_table[slot] = prd_state;
        return prd_prev;
    endfunction

    task automatic add_request(logic op, value_t seed, bit drain_first);
        request_t req;
        req.op = op;
        req.seed = seed;
        req.drain_first = drain_first;
        pending_requests.push_back(req);
    endtask

    function automatic value_t pick_seed();
        case ($urandom_range(9))
            0: return '0;
            1: return SEED_ONE;
            2: return LEHMER_MOD;
            3: return LEHMER_MOD - 1;
            default: return value_t'($urandom);
        endcase
    endfunction

    // Driver: hold an offered item until it is taken, otherwise offer the next.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        bit holding;
        bit idle;
        if (!rst_n)
        begin
            draw_if.valid <= 1'b0;
            draw_if.op <= OP_DRAW;
            draw_if.seed <= '0;
        end
        else
        begin
            holding = draw_if.valid && !draw_if.ready;
            if (draw_if.valid && draw_if.ready)
            begin
                expected_values.push_back(predict_value(draw_if.op, draw_if.seed));
                pending_requests.delete(0);
                sent_count++;
            end
            if (!holding)
            begin
                idle = (sent_count < CALM_FIRST || sent_count >= CALM_LAST)
                    && ($urandom_range(99) < IDLE_PCT);
                if (pending_requests.size() != 0 && !idle
                    && !(pending_requests[0].drain_first && expected_values.size() != 0))
                begin
                    draw_if.valid <= 1'b1;
                    draw_if.op <= pending_requests[0].op;
                    draw_if.seed <= pending_requests[0].seed;
                end
                else
                    draw_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result item with the oldest predicted value.
    always @(posedge clk or negedge rst_n)
    begin : collect_results
        value_t want;
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                got_count++;
                if (expected_values.size() == 0)
                    report_mismatch($sformatf("unexpected value %0d", result_if.value));
                else
                begin
                    want = expected_values.pop_front();
                    if (result_if.value !== want)
                        report_mismatch($sformatf("value %0d, predicted %0d",
                                                  result_if.value, want));
                end
            end
            result_if.ready <= !rx_hold
                && ((got_count >= CALM_FIRST && got_count < CALM_LAST)
                    || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Long receiver stall so the block backs up and stalls its input.
    initial
    begin : receiver_hold_off
        wait (got_count >= RX_HOLD_AT);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin : run_sequence
        int run_len;
        prd_state = SEED_ONE;
        prd_prev = '0;
        foreach (prd_table[i])
            prd_table[i] = '0;

        // Directed: draws before any seeding, then the seed extremes.
        add_request(OP_DRAW, LEHMER_MOD, 1'b0);
        add_request(OP_DRAW, '0, 1'b0);
        add_request(OP_DRAW, value_t'(31'h2AAA_AAAA), 1'b0);
        add_request(OP_RESEED, '0, 1'b0);
        add_request(OP_DRAW, '0, 1'b0);
        add_request(OP_DRAW, LEHMER_MOD, 1'b0);
        add_request(OP_RESEED, LEHMER_MOD, 1'b0);
        add_request(OP_DRAW, '0, 1'b0);
        add_request(OP_RESEED, LEHMER_MOD - 1, 1'b0);
        add_request(OP_DRAW, value_t'(31'h5555_5555), 1'b0);
        add_request(OP_RESEED, SEED_ONE, 1'b0);
        add_request(OP_DRAW, '0, 1'b0);
        add_request(OP_RESEED, value_t'(31'h5555_5555), 1'b1);
        add_request(OP_RESEED, value_t'(31'h2AAA_AAAA), 1'b0);
        for (int i = 0; i < 6; i++)
            add_request(OP_DRAW, value_t'($urandom), 1'b0);
        add_request(OP_RESEED, value_t'(31'h4000_0000), 1'b0);
        add_request(OP_DRAW, '0, 1'b0);

        // Random: mostly a reseed followed by a run of draws, some noise.
        while (pending_requests.size() < ITEM_TARGET)
        begin
            if ($urandom_range(99) < 85)
            begin
                add_request(OP_RESEED, pick_seed(),
                            pending_requests.size() % 500 >= 250
                            && pending_requests.size() % 500 < 290);
                run_len = $urandom_range(40, 4);
                for (int i = 0; i < run_len; i++)
                    add_request(OP_DRAW, value_t'($urandom), 1'b0);
            end
            else if ($urandom_range(1) == 0)
            begin
                add_request(OP_RESEED, pick_seed(), 1'b0);
                add_request(OP_RESEED, pick_seed(), 1'b0);
            end
            else
                add_request(OP_DRAW, pick_seed(), 1'b0);
        end

        wait (rst_n === 1'b1);
        wait (pending_requests.size() == 0);
        wait (expected_values.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== lehmer_prng_with_shuffle_top.f =====
rtl/core/lps_pkg.sv
rtl/core/lps_in_if.sv
rtl/core/lps_out_if.sv
rtl/core/lps_ram.sv
rtl/core/lps_ctrl.sv
rtl/core/lps_datapath.sv
rtl/core/lehmer_prng_with_shuffle_top.sv
dv/tb_lehmer_prng_with_shuffle_top.sv
